### src/msb_pkg.sv
// shared types and constants of the masked sprite blitter
`timescale 1ns / 1ps

package msb_pkg;

    localparam int DATA_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int ADDR_W          = 13;
    localparam int FULL_ADDR_W     = 19;
    localparam int FB_BYTES        = 8192;
    localparam int MAX_WIDTH_BYTES = 32;
    localparam int COL_W           = 6;
    localparam int ROW_W           = 9;
    localparam int POS_W           = 11;
    localparam int EFF_W           = 10;
    localparam int SIZE_W          = 9;
    localparam int STRIDE_W        = 8;
    localparam int SCREEN_W        = 11;
    localparam int SHIFT_W         = 3;
    localparam int SETTLE_W        = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_POS         = 3'd0,
        CFG_Y_POS         = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_IMAGE_HEIGHT  = 3'd3,
        CFG_STRIDE_BYTES  = 3'd4,
        CFG_SCREEN_WIDTH  = 3'd5,
        CFG_SCREEN_HEIGHT = 3'd6
    } t_cfg_idx;

    // blit geometry derived from the configuration
    typedef struct packed {
        logic [SHIFT_W-1:0]     shift;
        logic [COL_W-1:0]       cols;
        logic [ROW_W-1:0]       height;
        logic [STRIDE_W-1:0]    stride;
        logic [FULL_ADDR_W-1:0] start;
    } t_geom;

    // configuration status toward the datapath
    typedef struct packed {
        logic restart;
        logic busy;
    } t_cfg_stat;

endpackage

### src/masked_sprite_blitter.sv
// Masked 1 bit per pixel sprite blitter, read-modify-write byte stream.
//
// Each input transfer is one destination byte in row order: the next sprite
// image and mask bytes plus the old framebuffer byte at the address that
// its result reports. Each output transfer carries the address,
// the merged byte (old AND mask OR image), a row end mark, a last mark and
// an off_screen flag that means the write must be dropped.
// When x is not a multiple of 8 each row takes one extra column whose source
// fields are ignored.
// Throughput is one byte per cycle while o_in_stall is low; a result is
// valid in the cycle after its input transfer (single result register).
// A configuration write to a known index restarts the blit; the geometry
// is then recomputed in the geometry stages, during which o_in_stall is
// high, also after reset. After the last byte the same blit starts again.
// When the receiver stalls, the result register holds and o_in_stall rises,
// so no result is lost.
`timescale 1ns / 1ps

module masked_sprite_blitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [msb_pkg::DATA_W-1:0]     i_src_bits,
    input  logic [msb_pkg::DATA_W-1:0]     i_src_mask,
    input  logic [msb_pkg::DATA_W-1:0]     i_old_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [msb_pkg::ADDR_W-1:0]     o_address,
    output logic [msb_pkg::DATA_W-1:0]     o_new_byte,
    output logic                           o_row_end,
    output logic                           o_last,
    output logic                           o_off_screen
);
    import msb_pkg::*;

    t_geom     geom;
    t_cfg_stat stat;

    logic [DATA_W-1:0]      r_prev_bits;
    logic [DATA_W-1:0]      r_prev_mask;
    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic [FULL_ADDR_W-1:0] r_row_off;

    logic                   r_out_valid;
    logic [ADDR_W-1:0]      r_address;
    logic [DATA_W-1:0]      r_new_byte;
    logic                   r_row_end;
    logic                   r_last;
    logic                   r_off_screen;

    logic                   accept;
    logic                   shifted;
    logic                   row_end;
    logic                   last;
    logic [FULL_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]      hi_mask;
    logic [DATA_W-1:0]      lo_mask;
    logic [DATA_W-1:0]      hi_bits;
    logic [DATA_W-1:0]      lo_bits;
    logic [2*DATA_W-1:0]    mask_pair;
    logic [2*DATA_W-1:0]    bits_pair;
    logic [DATA_W-1:0]      n_new_byte;

    msb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom),
        .o_stat      (stat)
    );

    // input transfer when settled and the result register can take a byte
    assign o_in_stall = stat.busy | (r_out_valid & i_out_stall);
    assign accept     = i_in_valid & ~o_in_stall;

    // position in the blit
    assign shifted = (geom.shift != '0);
    assign row_end = (r_col == geom.cols - 1'b1);
    assign last    = row_end && (({1'b0, r_row} + 1'b1) >= {1'b0, geom.height});
    assign addr    = geom.start + r_row_off + FULL_ADDR_W'(r_col);

    // join kept byte and new byte, shifted right by x mod 8;
    // the first column takes transparent kept data, the extra column
    // takes transparent new data
    always_comb begin
        hi_mask    = (r_col == '0) ? {DATA_W{1'b1}} : r_prev_mask;
        hi_bits    = (r_col == '0) ? '0 : r_prev_bits;
        lo_mask    = (shifted && row_end) ? {DATA_W{1'b1}} : i_src_mask;
        lo_bits    = (shifted && row_end) ? '0 : i_src_bits;
        mask_pair  = {hi_mask, lo_mask} >> geom.shift;
        bits_pair  = {hi_bits, lo_bits} >> geom.shift;
        n_new_byte = (i_old_byte & mask_pair[DATA_W-1:0]) | bits_pair[DATA_W-1:0];
    end

    // counters and kept source bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || stat.restart) begin
            r_prev_bits <= '0;
            r_prev_mask <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_row_off   <= '0;
        end else if (accept) begin
            if (last) begin
                r_prev_bits <= '0;
                r_prev_mask <= '0;
                r_col       <= '0;
                r_row       <= '0;
                r_row_off   <= '0;
            end else begin
                if (!(shifted && row_end)) begin
                    r_prev_bits <= i_src_bits;
                    r_prev_mask <= i_src_mask;
                end
                if (row_end) begin
                    r_col     <= '0;
                    r_row     <= r_row + 1'b1;
                    r_row_off <= r_row_off + FULL_ADDR_W'(geom.stride);
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_address    <= addr[ADDR_W-1:0];
            r_new_byte   <= n_new_byte;
            r_row_end    <= row_end;
            r_last       <= last;
            r_off_screen <= (addr >= FULL_ADDR_W'(FB_BYTES));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_address    = r_address;
    assign o_new_byte   = r_new_byte;
    assign o_row_end    = r_row_end;
    assign o_last       = r_last;
    assign o_off_screen = r_off_screen;

endmodule

### src/msb_cfg.sv
// configuration registers and registered blit geometry
`timescale 1ns / 1ps

module msb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output msb_pkg::t_geom                 o_geom,
    output msb_pkg::t_cfg_stat             o_stat
);
    import msb_pkg::*;

    logic [POS_W-1:0]    r_x_pos;
    logic [POS_W-1:0]    r_y_pos;
    logic [SIZE_W-1:0]   r_image_width;
    logic [SIZE_W-1:0]   r_image_height;
    logic [STRIDE_W-1:0] r_stride;
    logic [SCREEN_W-1:0] r_screen_width;
    logic [SCREEN_W-1:0] r_screen_height;
    logic [SETTLE_W-1:0] r_settle;

    logic [EFF_W-1:0]       r_eff_x;
    logic [EFF_W-1:0]       r_eff_y;
    logic [COL_W-1:0]       r_cols;
    logic [ROW_W-1:0]       r_height;
    logic [FULL_ADDR_W-1:0] r_start;

    logic                   write_hit;
    logic [EFF_W-1:0]       n_eff_x;
    logic [EFF_W-1:0]       n_eff_y;
    logic [SIZE_W-2:0]      wb_raw;
    logic [COL_W-1:0]       wb;
    logic [COL_W-1:0]       n_cols;
    logic [ROW_W-1:0]       n_height;
    logic [FULL_ADDR_W-1:0] n_start;

    // negative position centres the sprite, saturating at zero
    function automatic logic [EFF_W-1:0] centred(
        input logic [POS_W-1:0]    pos,
        input logic [SCREEN_W-1:0] screen,
        input logic [SIZE_W-1:0]   size
    );
        logic [SCREEN_W-1:0] diff;
        diff = screen - {{(SCREEN_W-SIZE_W){1'b0}}, size};
        if (!pos[POS_W-1]) begin
            centred = pos[EFF_W-1:0];
        end else if ({{(SCREEN_W-SIZE_W){1'b0}}, size} >= screen) begin
            centred = '0;
        end else begin
            centred = diff[SCREEN_W-1:1];
        end
    endfunction

    assign o_cfg_ready = 1'b1;

    // register writes; an index beyond the list is ignored
    always_comb begin
        case (i_cfg_index)
            CFG_X_POS, CFG_Y_POS, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT,
            CFG_STRIDE_BYTES, CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT: write_hit = i_cfg_valid;
            default: write_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_pos         <= '0;
            r_y_pos         <= '0;
            r_image_width   <= SIZE_W'(8);
            r_image_height  <= SIZE_W'(8);
            r_stride        <= STRIDE_W'(30);
            r_screen_width  <= SCREEN_W'(240);
            r_screen_height <= SCREEN_W'(208);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X_POS:         r_x_pos         <= i_cfg_data[POS_W-1:0];
                CFG_Y_POS:         r_y_pos         <= i_cfg_data[POS_W-1:0];
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[SIZE_W-1:0];
                CFG_STRIDE_BYTES:  r_stride        <= i_cfg_data[STRIDE_W-1:0];
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    // settle counter holds off items until the geometry pipeline is updated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYCLES;
        end else if (write_hit) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    // first geometry stage: effective position, columns and rows
    always_comb begin
        n_eff_x = centred(r_x_pos, r_screen_width, r_image_width);
        n_eff_y = centred(r_y_pos, r_screen_height, r_image_height);
        wb_raw  = (SIZE_W-1)'(({1'b0, r_image_width} + 10'd7) >> 3);
        if (wb_raw == '0) begin
            wb = COL_W'(1);
        end else if (wb_raw > (SIZE_W-1)'(MAX_WIDTH_BYTES)) begin
            wb = COL_W'(MAX_WIDTH_BYTES);
        end else begin
            wb = wb_raw[COL_W-1:0];
        end
        n_cols   = wb + COL_W'(n_eff_x[SHIFT_W-1:0] != '0);
        n_height = (r_image_height == '0) ? ROW_W'(1) : r_image_height;
    end

    always_ff @(posedge i_clk) begin
        r_eff_x  <= n_eff_x;
        r_eff_y  <= n_eff_y;
        r_cols   <= n_cols;
        r_height <= n_height;
    end

    // second geometry stage: start byte address
    assign n_start = FULL_ADDR_W'(r_eff_x[EFF_W-1:SHIFT_W])
                   + FULL_ADDR_W'(r_stride) * FULL_ADDR_W'(r_eff_y);

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

    assign o_geom.shift   = r_eff_x[SHIFT_W-1:0];
    assign o_geom.cols    = r_cols;
    assign o_geom.height  = r_height;
    assign o_geom.stride  = r_stride;
    assign o_geom.start   = r_start;
    assign o_stat.restart = write_hit;
    assign o_stat.busy    = (r_settle != '0);

endmodule

### test/masked_sprite_blitter_test.sv
// self-checking testbench of the masked sprite blitter with a byte-level blit predictor
`timescale 1ns / 1ps

module masked_sprite_blitter_test;
    import msb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 150;

    typedef struct {
        logic [DATA_W-1:0] src_bits;
        logic [DATA_W-1:0] src_mask;
        logic [DATA_W-1:0] old_byte;
    } t_blit_item;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] new_byte;
        logic              row_end;
        logic              last;
        logic              off_screen;
    } t_blit_write;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_EVERY_THIRD,
        STALL_SPARSE
    } t_stall_mode;

    // block ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [DATA_W-1:0]     i_src_bits = '0;
    logic [DATA_W-1:0]     i_src_mask = '0;
    logic [DATA_W-1:0]     i_old_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ADDR_W-1:0]     o_address;
    logic [DATA_W-1:0]     o_new_byte;
    logic                  o_row_end;
    logic                  o_last;
    logic                  o_off_screen;

    // predictor copy of the registers
    logic [POS_W-1:0]    reg_x;
    logic [POS_W-1:0]    reg_y;
    logic [SIZE_W-1:0]   reg_width;
    logic [SIZE_W-1:0]   reg_height;
    logic [STRIDE_W-1:0] reg_stride;
    logic [SCREEN_W-1:0] reg_screen_w;
    logic [SCREEN_W-1:0] reg_screen_h;

    // predictor walk state
    logic [DATA_W-1:0] kept_bits;
    logic [DATA_W-1:0] kept_mask;
    bit [31:0]         col_idx;
    bit [31:0]         row_idx;
    bit [31:0]         row_base;

    t_blit_item  pending_items[$];
    t_blit_write expected_writes[$];
    t_blit_item  cur_item;

    int errors = 0;
    int results_seen = 0;

    // sender burst state
    int burst_left = 1;
    int gap_left = 0;
    bit drain_wait = 1'b0;

    // receiver stall state
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned tick = 0;

    masked_sprite_blitter u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_src_bits   (i_src_bits),
        .i_src_mask   (i_src_mask),
        .i_old_byte   (i_old_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_address    (o_address),
        .o_new_byte   (o_new_byte),
        .o_row_end    (o_row_end),
        .o_last       (o_last),
        .o_off_screen (o_off_screen)
    );

    // clock
    initial begin : clock_gen
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // negative position centres, saturating at 0
    function automatic bit [31:0] centre_pos(input logic [POS_W-1:0] pos,
                                             input logic [SCREEN_W-1:0] screen,
                                             input logic [SIZE_W-1:0] span);
        bit [31:0] s;
        bit [31:0] z;
        s = 32'(screen);
        z = 32'(span);
        if (!pos[POS_W-1]) return 32'(pos[EFF_W-1:0]);
        if (z >= s) return 0;
        return (s - z) / 2;
    endfunction

    function automatic bit [31:0] origin_x();
        return centre_pos(reg_x, reg_screen_w, reg_width);
    endfunction

    function automatic bit [31:0] origin_y();
        return centre_pos(reg_y, reg_screen_h, reg_height);
    endfunction

    // sprite width in bytes, at least one, capped
    function automatic bit [31:0] sprite_bytes();
        bit [31:0] wb;
        wb = 32'(reg_width);
        wb = (wb + 7) >> 3;
        if (wb < 1) wb = 1;
        if (wb > MAX_WIDTH_BYTES) wb = MAX_WIDTH_BYTES;
        return wb;
    endfunction

    function automatic bit [31:0] sprite_rows();
        bit [31:0] h;
        h = 32'(reg_height);
        return (h < 1) ? 1 : h;
    endfunction

    function automatic void restart_blit();
        bit [31:0] stride;
        stride = 32'(reg_stride);
        kept_bits = '0;
        kept_mask = '0;
        col_idx = 0;
        row_idx = 0;
        row_base = (origin_x() >> 3) + stride * origin_y();
    endfunction

    function automatic void reset_predictor();
        reg_x = '0;
        reg_y = '0;
        reg_width = SIZE_W'(8);
        reg_height = SIZE_W'(8);
        reg_stride = STRIDE_W'(30);
        reg_screen_w = SCREEN_W'(240);
        reg_screen_h = SCREEN_W'(208);
        restart_blit();
    endfunction

    // register write; any known index restarts the blit
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_X_POS:         reg_x = data[POS_W-1:0];
            CFG_Y_POS:         reg_y = data[POS_W-1:0];
            CFG_IMAGE_WIDTH:   reg_width = data[SIZE_W-1:0];
            CFG_IMAGE_HEIGHT:  reg_height = data[SIZE_W-1:0];
            CFG_STRIDE_BYTES:  reg_stride = data[STRIDE_W-1:0];
            CFG_SCREEN_WIDTH:  reg_screen_w = data[SCREEN_W-1:0];
            CFG_SCREEN_HEIGHT: reg_screen_h = data[SCREEN_W-1:0];
            default:           return;
        endcase
        restart_blit();
    endfunction

    // one destination byte: shift and join sprite bytes, merge into old byte
    function automatic t_blit_write merge_byte(input t_blit_item it);
        bit [31:0]   shift;
        bit [31:0]   cols;
        bit [31:0]   m;
        bit [31:0]   img;
        bit [31:0]   addr;
        bit [31:0]   bits;
        bit [31:0]   mask;
        bit [31:0]   kb;
        bit [31:0]   km;
        bit [31:0]   stride;
        t_blit_write r;
        shift = origin_x() & 7;
        cols = sprite_bytes() + ((shift != 0) ? 1 : 0);
        bits = 32'(it.src_bits);
        mask = 32'(it.src_mask);
        kb = 32'(kept_bits);
        km = 32'(kept_mask);
        stride = 32'(reg_stride);
        if (col_idx >= cols) col_idx = cols - 1;
        if (shift == 0) begin
            m = mask;
            img = bits;
        end else if (col_idx == 0) begin
            m = (32'hFF00 >> shift) | (mask >> shift);
            img = bits >> shift;
        end else if (col_idx == cols - 1) begin
            // extra column: only the kept bytes count
            m = (km << (8 - shift)) | (32'hFF >> shift);
            img = kb << (8 - shift);
        end else begin
            m = (km << (8 - shift)) | (mask >> shift);
            img = (kb << (8 - shift)) | (bits >> shift);
        end
        addr = row_base + col_idx;
        r.address = addr[ADDR_W-1:0];
        r.new_byte = (it.old_byte & m[DATA_W-1:0]) | img[DATA_W-1:0];
        r.row_end = (col_idx == cols - 1);
        r.last = r.row_end && (row_idx + 1 >= sprite_rows());
        r.off_screen = (addr >= FB_BYTES);
        if (!(shift != 0 && r.row_end)) begin
            kept_bits = it.src_bits;
            kept_mask = it.src_mask;
        end
        if (r.last) begin
            restart_blit();
        end else if (r.row_end) begin
            col_idx = 0;
            row_idx++;
            row_base += stride;
        end else begin
            col_idx++;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // input driver: bursts with gaps, sometimes draining before the next burst
    always @(posedge i_clk) begin : drive_items
        logic offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_writes.push_back(merge_byte(cur_item));
                offering = 1'b0;
            end
            if (!offering) begin
                if (drain_wait && expected_writes.size() == 0) drain_wait = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (drain_wait || pending_items.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    cur_item = pending_items.pop_front();
                    i_src_bits <= cur_item.src_bits;
                    i_src_mask <= cur_item.src_mask;
                    i_old_byte <= cur_item.old_byte;
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                        drain_wait = ($urandom_range(0, 11) == 0);
                    end
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin : watch_results
        t_blit_write want;
        logic        stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual address 0x%0h",
                             $time, o_address);
                    errors++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("address", 32'(want.address), 32'(o_address));
                    check_field("new_byte", 32'(want.new_byte), 32'(o_new_byte));
                    check_field("row_end", 32'(want.row_end), 32'(o_row_end));
                    check_field("last", 32'(want.last), 32'(o_last));
                    check_field("off_screen", 32'(want.off_screen), 32'(o_off_screen));
                end
            end
            // one long hold-off while the sender still has plenty queued
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!hold_done && results_seen >= 50 && pending_items.size() >= 20) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(4, 64);
                end else begin
                    mode_left--;
                end
                tick++;
                case (stall_mode)
                    STALL_NONE:        stall_next = 1'b0;
                    STALL_HALF:        stall_next = ($urandom_range(0, 1) == 1);
                    STALL_EVERY_THIRD: stall_next = (tick % 3 == 0);
                    default:           stall_next = ($urandom_range(0, 4) == 0);
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // register value in the low bits, random junk above
    task automatic write_field(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] value,
                               input int width);
        bit [31:0] keep;
        bit [31:0] data;
        keep = (32'd1 << width) - 1;
        data = $urandom;
        data = (data & ~keep) | (value & keep);
        write_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic set_geometry(input bit [31:0] x, input bit [31:0] y, input bit [31:0] w,
                                input bit [31:0] h, input bit [31:0] st, input bit [31:0] sw,
                                input bit [31:0] sh);
        write_field(CFG_X_POS, x, POS_W);
        write_field(CFG_Y_POS, y, POS_W);
        write_field(CFG_IMAGE_WIDTH, w, SIZE_W);
        write_field(CFG_IMAGE_HEIGHT, h, SIZE_W);
        write_field(CFG_STRIDE_BYTES, st, STRIDE_W);
        write_field(CFG_SCREEN_WIDTH, sw, SCREEN_W);
        write_field(CFG_SCREEN_HEIGHT, sh, SCREEN_W);
    endtask

    // mostly small sprites near the origin, with the odd extreme
    task automatic random_geometry();
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] w;
        bit [31:0] h;
        bit [31:0] st;
        bit [31:0] sw;
        bit [31:0] sh;
        case ($urandom_range(0, 7))
            0:       x = 32'h400 | $urandom_range(0, 1023);
            1:       x = 1023;
            2, 3:    x = $urandom_range(0, 1023);
            default: x = $urandom_range(0, 63);
        endcase
        case ($urandom_range(0, 7))
            0:       y = 32'h400 | $urandom_range(0, 1023);
            1:       y = 1023;
            2:       y = $urandom_range(0, 1023);
            default: y = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 256;
            2:       w = 511;
            3:       w = $urandom_range(0, 511);
            default: w = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1:       h = 256;
            2:       h = 511;
            3:       h = $urandom_range(0, 511);
            default: h = $urandom_range(1, 5);
        endcase
        case ($urandom_range(0, 7))
            0:       st = 0;
            1:       st = 255;
            2:       st = 128;
            3:       st = 1;
            default: st = $urandom_range(8, 40);
        endcase
        case ($urandom_range(0, 5))
            0:       sw = 0;
            1:       sw = 2047;
            2:       sw = $urandom_range(0, 2047);
            default: sw = $urandom_range(8, 1024);
        endcase
        case ($urandom_range(0, 5))
            0:       sh = 0;
            1:       sh = 2047;
            2:       sh = $urandom_range(0, 2047);
            default: sh = $urandom_range(1, 1024);
        endcase
        set_geometry(x, y, w, h, st, sw, sh);
    endtask

    task automatic push_item(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] m,
                             input logic [DATA_W-1:0] o);
        t_blit_item it;
        it.src_bits = b;
        it.src_mask = m;
        it.old_byte = o;
        pending_items.push_back(it);
    endtask

    // random source, mask and old bytes
    task automatic push_random();
        push_item(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
    endtask

    // wait until every transfer has come back, then let the block settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_writes.size() != 0);
        repeat (int'(SETTLE_CYCLES) + 1) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin : run_blits
        int sent;
        int n;
        reset_predictor();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, aligned 8x8, one full blit
        push_item(8'h00, 8'h00, 8'h00);
        push_item(8'hFF, 8'hFF, 8'hFF);
        push_item(8'hFF, 8'h00, 8'h00);
        push_item(8'h00, 8'hFF, 8'hFF);
        push_item(8'hAA, 8'h55, 8'hF0);
        push_item(8'h55, 8'hAA, 8'h0F);
        push_item(8'h00, 8'hFF, 8'h00);
        push_item(8'hFF, 8'hFF, 8'h00);
        wait_idle();

        // unaligned x, first, middle and extra columns over two rows
        set_geometry(3, 0, 9, 2, 2, 240, 208);
        push_item(8'hFF, 8'h00, 8'h00);
        push_item(8'hFF, 8'h00, 8'hFF);
        push_item(8'h00, 8'hFF, 8'hFF);
        push_item(8'h81, 8'h7E, 8'h55);
        push_item(8'h00, 8'h00, 8'hAA);
        push_item(8'h5A, 8'hA5, 8'h00);
        wait_idle();

        // centred on both axes
        set_geometry(32'h7FF, 32'h7FF, 16, 2, 30, 100, 10);
        repeat (4) push_random();
        wait_idle();

        // far corner: zero width and height, beyond the framebuffer
        set_geometry(1023, 1023, 0, 0, 128, 240, 208);
        repeat (3) push_random();
        wait_idle();

        // sprite larger than the screen, zero stride
        set_geometry(32'h7FF, 32'h7FF, 511, 511, 0, 8, 1);
        repeat (2) push_random();
        wait_idle();

        // write to an unused index mid-blit
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        repeat (2) push_random();
        wait_idle();

        // random phases, some continuing the previous blit
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) random_geometry();
            if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            n = $urandom_range(20, 80);
            repeat (n) push_random();
            sent += n;
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/msb_pkg.sv
src/msb_cfg.sv
src/masked_sprite_blitter.sv
test/masked_sprite_blitter_test.sv
